FILE: design/ac_rms_meter_with_smoothing_defines.svh
// Assertion macros for the RMS meter.
`ifndef AC_RMS_METER_WITH_SMOOTHING_DEFINES_SVH
`define AC_RMS_METER_WITH_SMOOTHING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ARM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARM_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define ARM_ASSERT(lbl, prop, msg)
`define ARM_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

FILE: design/arm_pkg.sv
// Shared constants and types of the RMS meter.
`default_nettype none
package arm_pkg;
    localparam int MAX_WINDOW  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_W       = 13;
    localparam int SUM_W       = 29;
    localparam int MEAN_W      = 25;

    localparam logic [2:0] REG_WINDOW_LEN    = 3'd0;
    localparam logic [2:0] REG_SMOOTH_WEIGHT = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_SCALE = 3'd2;
    localparam logic [2:0] REG_CURRENT_SCALE = 3'd3;
    localparam logic [2:0] REG_CURRENT_FLOOR = 3'd4;
    localparam logic [2:0] REG_VOLTAGE_START = 3'd5;

    localparam logic [12:0] WINDOW_LEN_RST    = 13'd17;
    localparam logic [15:0] SMOOTH_WEIGHT_RST = 16'd26214;
    localparam logic [23:0] VOLTAGE_SCALE_RST = 24'd1615952;
    localparam logic [23:0] CURRENT_SCALE_RST = 24'd34342;
    localparam logic [15:0] CURRENT_FLOOR_RST = 16'd983;
    localparam logic [31:0] VOLTAGE_START_RST = 32'd14417920;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_MEAN_DIV  = 9'b000000010,
        ST_SQ_MUL    = 9'b000000100,
        ST_RMS_DIV   = 9'b000001000,
        ST_SQRT      = 9'b000010000,
        ST_SCALE_MUL = 9'b000100000,
        ST_EMA_MUL1  = 9'b001000000,
        ST_EMA_MUL2  = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

FILE: design/ac_rms_meter_with_smoothing.sv
// Top level: per-channel offset removal, RMS, scaling and exponential smoothing.
// A mean-window word is taken at once; a closing one waits for the 64-step divider.
// An RMS-window word runs the serial square; the closing word goes on through square,
// 64-step divider, 32-step root and three 32-step multiplies, plus any wait for the output.
// Reset is asynchronous: registers return to defaults, both channels start a mean window.
`default_nettype none
`include "ac_rms_meter_with_smoothing_defines.svh"
module ac_rms_meter_with_smoothing
    import arm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // sample
    input  wire logic        s_axis_tuser,  // channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // rms_code, smoothed_value
    output logic             m_axis_tuser   // out_channel
);
    state_t state_reg, state_next;

    logic [12:0] window_len_reg;
    logic [15:0] smooth_weight_reg;
    logic [23:0] voltage_scale_reg;
    logic [23:0] current_scale_reg;
    logic [15:0] current_floor_reg;

    logic [1:0]              phase_reg;
    logic [1:0][LEN_W-1:0]   count_reg;
    logic [1:0][SUM_W-1:0]   sum_reg;
    logic [1:0][MEAN_W-1:0]  mean_reg;
    logic [1:0][63:0]        sq_reg;
    logic [1:0][31:0]        smooth_reg;

    logic             ch_reg;
    logic             neg_reg;
    logic [LEN_W-1:0] n_reg;
    logic [31:0]      inst_reg;
    logic [31:0]      res_value_reg;
    logic [23:0]      res_rms_reg;
    logic             out_valid_reg;
    logic             out_ch_reg;
    logic [31:0]      out_value_reg;
    logic [23:0]      out_rms_reg;

    logic mul_start, mul_busy, mul_done;
    logic div_start, div_busy, div_done;
    logic sqrt_start, sqrt_busy, sqrt_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_add, mul_p;
    logic [63:0] div_in, div_q;
    logic [LEN_W-1:0] div_r;
    logic [31:0] root;

    logic             in_acc;
    logic             ch;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] n_new;
    logic [SUM_W-1:0] sum_new;
    logic [37:0]      num;
    logic [37:0]      num_mag;
    logic [25:0]      dev;
    logic [24:0]      dev_mag;
    logic [MEAN_W-1:0] mean_q;
    logic [23:0]      rms_sat;
    logic [32:0]      acc_sh;
    logic [31:0]      acc_sat;
    logic [31:0]      acc_fin;
    logic             out_free;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign ch       = s_axis_tuser;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        priority if (window_len_reg == 13'd0)
            len_eff = 13'd1;
        else if (window_len_reg > 13'(MAX_WINDOW))
            len_eff = 13'(MAX_WINDOW);
        else
            len_eff = window_len_reg;
    end

    assign n_new   = count_reg[ch] + 13'd1;
    assign sum_new = sum_reg[ch] + {{(SUM_W-SAMPLE_BITS){s_axis_tdata[15]}}, s_axis_tdata};
    // Rounded numerator of the mean in steps of 1/256: sum * 256 + n / 2.
    assign num     = {sum_new[SUM_W-1], sum_new, 8'd0} + {26'd0, n_new[12:1]};
    assign num_mag = num[37] ? -num : num;
    assign dev     = {{2{s_axis_tdata[15]}}, s_axis_tdata, 8'd0}
                   - {mean_reg[ch][MEAN_W-1], mean_reg[ch]};
    assign dev_mag = dev[25] ? 25'(-dev) : dev[24:0];

    // Floor division: a negative numerator with a remainder rounds one further down.
    assign mean_q  = neg_reg ? MEAN_W'(-(div_q[24:0] + {24'd0, div_r != '0})) : div_q[24:0];
    assign rms_sat = (root > 32'hFFFFFF) ? 24'hFFFFFF : root[23:0];
    assign acc_sh  = mul_p[48:16];
    assign acc_sat = acc_sh[32] ? 32'hFFFFFFFF : acc_sh[31:0];
    assign acc_fin = (ch_reg && acc_sat < {16'd0, current_floor_reg}) ? 32'd0 : acc_sat;

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = {7'd0, dev_mag};
        mul_b      = {7'd0, dev_mag};
        mul_add    = sq_reg[ch];
        div_in     = {26'd0, num_mag};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!phase_reg[ch])
                    begin
                        if (n_new >= len_eff)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_MEAN_DIV;
                        end
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_SQ_MUL;
                    end
                end
            end
            ST_MEAN_DIV:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            ST_SQ_MUL:
            begin
                div_in = mul_p;
                if (mul_done)
                begin
                    if (n_reg < len_eff)
                        state_next = ST_IDLE;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_RMS_DIV;
                    end
                end
            end
            ST_RMS_DIV:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                mul_a   = {8'd0, rms_sat};
                mul_b   = {8'd0, ch_reg ? current_scale_reg : voltage_scale_reg};
                mul_add = 64'd32768;
                if (sqrt_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SCALE_MUL;
                end
            end
            ST_SCALE_MUL:
            begin
                mul_a   = smooth_reg[ch_reg];
                mul_b   = 32'h10000 - {16'd0, smooth_weight_reg};
                mul_add = 64'd32768;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_EMA_MUL1;
                end
            end
            ST_EMA_MUL1:
            begin
                mul_a   = inst_reg;
                mul_b   = {16'd0, smooth_weight_reg};
                mul_add = mul_p;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_EMA_MUL2;
                end
            end
            ST_EMA_MUL2:
            begin
                if (mul_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_len_reg    <= WINDOW_LEN_RST;
            smooth_weight_reg <= SMOOTH_WEIGHT_RST;
            voltage_scale_reg <= VOLTAGE_SCALE_RST;
            current_scale_reg <= CURRENT_SCALE_RST;
            current_floor_reg <= CURRENT_FLOOR_RST;
            phase_reg         <= '0;
            count_reg         <= '0;
            sum_reg           <= '0;
            mean_reg          <= '0;
            sq_reg            <= '0;
            // Voltage smoothing starts at its default; REG_VOLTAGE_START writes are ignored.
            smooth_reg[0]     <= VOLTAGE_START_RST;
            smooth_reg[1]     <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LEN:    window_len_reg    <= cfg_data[12:0];
                    REG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_data[15:0];
                    REG_VOLTAGE_SCALE: voltage_scale_reg <= cfg_data[23:0];
                    REG_CURRENT_SCALE: current_scale_reg <= cfg_data[23:0];
                    REG_CURRENT_FLOOR: current_floor_reg <= cfg_data[15:0];
                    REG_VOLTAGE_START: ;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && in_acc && !phase_reg[ch])
            begin
                count_reg[ch] <= n_new;
                sum_reg[ch]   <= sum_new;
            end
            if (state_reg == ST_MEAN_DIV && div_done)
            begin
                mean_reg[ch_reg]  <= mean_q;
                phase_reg[ch_reg] <= 1'b1;
                count_reg[ch_reg] <= '0;
                sum_reg[ch_reg]   <= '0;
                sq_reg[ch_reg]    <= '0;
            end
            if (state_reg == ST_SQ_MUL && mul_done)
            begin
                sq_reg[ch_reg]    <= mul_p;
                count_reg[ch_reg] <= n_reg;
            end
            if (state_reg == ST_EMA_MUL2 && mul_done)
            begin
                smooth_reg[ch_reg] <= acc_fin;
                phase_reg[ch_reg]  <= 1'b0;
                count_reg[ch_reg]  <= '0;
                sum_reg[ch_reg]    <= '0;
                sq_reg[ch_reg]     <= '0;
            end
            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            ch_reg  <= ch;
            n_reg   <= n_new;
            neg_reg <= num[37];
        end
        if (state_reg == ST_SQRT && sqrt_done)
            res_rms_reg <= rms_sat;
        if (state_reg == ST_SCALE_MUL && mul_done)
            inst_reg <= mul_p[47:16];
        if (state_reg == ST_EMA_MUL2 && mul_done)
            res_value_reg <= acc_fin;
        if (state_reg == ST_FINISH && out_free)
        begin
            out_ch_reg    <= ch_reg;
            out_value_reg <= res_value_reg;
            out_rms_reg   <= res_rms_reg;
        end
    end

    arm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .addend  (mul_add),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    arm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_in),
        .divisor   (state_reg == ST_IDLE ? n_new : n_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    arm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (root)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rms_reg, out_value_reg};
    assign m_axis_tuser  = out_ch_reg;

    `ARM_ASSERT_IMPL(a_idle_units, in_acc, !mul_busy && !div_busy && !sqrt_busy,
        "word accepted while an arithmetic unit is busy")
    `ARM_ASSERT(a_one_unit, $onehot0({mul_busy, div_busy, sqrt_busy}),
        "more than one arithmetic unit busy")
    `ARM_ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid), $past(state_reg == ST_FINISH),
        "result word raised outside the finish step")
endmodule
`default_nettype wire

FILE: design/arm_mul.sv
// Shift-and-add multiplier with addend, one multiplier bit per cycle.
`default_nettype none
module arm_mul
    import arm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] mcand,
    input  wire logic [31:0] mplier,
    input  wire logic [63:0] addend,
    output logic             busy,
    output logic             done,
    output logic [63:0]      product
);
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = {32'd0, mcand};
            mplier_next = mplier;
            acc_next    = addend;
            cnt_next    = 5'd0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

FILE: design/arm_div.sv
// Restoring divider of a 64-bit word by the sample count, one quotient bit per cycle.
`default_nettype none
module arm_div
    import arm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [63:0]      dividend,
    input  wire logic [LEN_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [63:0]           quotient,
    output logic [LEN_W-1:0]      remainder
);
    logic [63:0]      quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = LEN_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

FILE: design/arm_sqrt.sv
// Integer square root of a 64-bit word, one root bit per cycle.
`default_nettype none
module arm_sqrt
    import arm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] val_reg, val_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial_rem;
    logic [34:0] trial;

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial_rem = {rem_reg[32:0], val_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            if (trial_rem >= trial)
            begin
                rem_next  = trial_rem - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial_rem;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

FILE: sim/tb_ac_rms_meter_with_smoothing.sv
// Testbench for the RMS meter: self-predicting stimulus with per-channel window tracking.
`default_nettype none
module tb_ac_rms_meter_with_smoothing;
    import arm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // sample
    logic        s_axis_tuser;   // channel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // rms_code, smoothed_value
    logic        m_axis_tuser;   // out_channel

    typedef struct packed {
        logic        chan;
        logic [31:0] level;
        logic [23:0] rms;
    } reading_t;

    // Register copy.
    logic [12:0] win_len;
    logic [15:0] weight;
    logic [23:0] v_scale;
    logic [23:0] i_scale;
    logic [15:0] i_floor;
    logic [31:0] v_start;

    // Per-channel state.
    logic        in_rms [2];
    int unsigned count [2];
    longint      total [2];
    longint      offset [2];
    logic [63:0] sq_total [2];
    logic [31:0] level [2];

    reading_t    pending_readings[$];
    int          errors;
    int          burst_left;
    int          stall_mode;

    ac_rms_meter_with_smoothing u_top (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_sample(input logic ch, input logic [15:0] raw);
        longint      s;
        longint      num;
        longint      q;
        longint      d;
        logic [63:0] ad;
        logic [63:0] rms;
        logic [63:0] inst;
        logic [63:0] acc;
        logic [23:0] scale;
        int unsigned len;
        int unsigned n;
        reading_t    r;
        len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW ? MAX_WINDOW : win_len);
        s = longint'($signed(raw));
        if (!in_rms[ch])
        begin
            total[ch] += s;
            count[ch]++;
            n = count[ch];
            if (n >= len)
            begin
                num = total[ch] * 256 + longint'(n / 2);
                q = num / longint'(n);
                if ((num % longint'(n)) != 0 && num < 0) q--;
                offset[ch] = q;
                in_rms[ch] = 1;
                count[ch] = 0;
                total[ch] = 0;
                sq_total[ch] = 0;
            end
        end
        else
        begin
            d = s * 256 - offset[ch];
            ad = (d < 0) ? -d : d;
            sq_total[ch] += ad * ad;
            count[ch]++;
            n = count[ch];
            if (n >= len)
            begin
                rms = int_sqrt(sq_total[ch] / n);
                if (rms > 64'hFFFFFF) rms = 64'hFFFFFF;
                scale = ch ? i_scale : v_scale;
                inst = (rms * scale + 32768) >> 16;
                if (inst > 64'hFFFFFFFF) inst = 64'hFFFFFFFF;
                acc = (64'd65536 - weight) * level[ch] + weight * inst + 32768;
                acc >>= 16;
                if (acc > 64'hFFFFFFFF) acc = 64'hFFFFFFFF;
                if (ch && acc < i_floor) acc = 0;
                level[ch] = acc[31:0];
                in_rms[ch] = 0;
                count[ch] = 0;
                total[ch] = 0;
                sq_total[ch] = 0;
                r.chan = ch;
                r.level = acc[31:0];
                r.rms = rms[23:0];
                pending_readings.push_back(r);
            end
        end
    endtask

    task automatic reset_model();
        win_len = WINDOW_LEN_RST;
        weight = SMOOTH_WEIGHT_RST;
        v_scale = VOLTAGE_SCALE_RST;
        i_scale = CURRENT_SCALE_RST;
        i_floor = CURRENT_FLOOR_RST;
        v_start = VOLTAGE_START_RST;
        for (int c = 0; c < 2; c++)
        begin
            in_rms[c] = 0;
            count[c] = 0;
            total[c] = 0;
            offset[c] = 0;
            sq_total[c] = 0;
            level[c] = 0;
        end
        level[0] = v_start;
    endtask

    // Waits for every reading, then a margin covering a word still in the pipe.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_LEN:    win_len = val[12:0];
            REG_SMOOTH_WEIGHT: weight = val[15:0];
            REG_VOLTAGE_SCALE: v_scale = val[23:0];
            REG_CURRENT_SCALE: i_scale = val[23:0];
            REG_CURRENT_FLOOR: i_floor = val[15:0];
            REG_VOLTAGE_START: v_start = val;
            default: ;
        endcase
    endtask

    // The word stays valid after acceptance; a gap or a drain drops tvalid.
    task automatic send_word(input logic ch, input logic [15:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ch;
        s_axis_tdata <= smp;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_sample(ch, smp);
    endtask

    function automatic logic [15:0] rand_sample(input int spread);
        int v;
        v = $urandom_range(0, 2 * spread) - spread + $urandom_range(0, 200) - 100;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic test_extremes();
        write_reg(REG_WINDOW_LEN, 13'd2);
        // Full-scale swings on both channels, and a zero-RMS constant on channel 1.
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h0000);
        send_word(1'b1, 16'h8000);
        send_word(1'b1, 16'h8000);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0001);
        send_word(1'b0, 16'h5555);
        send_word(1'b0, 16'hAAAA);
    endtask

    task automatic test_window_edges();
        // Zero length acts as one sample; an oversize length keeps the window open.
        write_reg(REG_WINDOW_LEN, 13'd0);
        repeat (4) send_word(1'b0, 16'($urandom));
        write_reg(REG_WINDOW_LEN, 13'd1);
        repeat (4) send_word(1'b1, 16'($urandom));
        write_reg(REG_WINDOW_LEN, 13'h1FFF);
        repeat (200) send_word(1'b0, rand_sample(3000));
        // Shorten the window mid-way: the next word closes it.
        write_reg(REG_WINDOW_LEN, 13'd8);
        repeat (5) send_word(1'b1, rand_sample(500));
        write_reg(REG_WINDOW_LEN, 13'd3);
        repeat (6) send_word(1'b1, rand_sample(500));
    endtask

    task automatic test_settings();
        write_reg(REG_SMOOTH_WEIGHT, 16'd0);
        write_reg(REG_VOLTAGE_SCALE, 24'hFFFFFF);
        write_reg(REG_CURRENT_SCALE, 24'hFFFFFF);
        write_reg(REG_CURRENT_FLOOR, 16'hFFFF);
        write_reg(REG_VOLTAGE_START, 32'hFFFFFFFF);
        for (int k = 0; k < 8; k++) send_word(k[0], rand_sample(32767));
        write_reg(REG_SMOOTH_WEIGHT, 16'hFFFF);
        for (int k = 0; k < 8; k++) send_word(k[1], rand_sample(32767));
        write_reg(REG_VOLTAGE_SCALE, 24'd0);
        write_reg(REG_CURRENT_SCALE, 24'd0);
        write_reg(REG_CURRENT_FLOOR, 16'd0);
        for (int k = 0; k < 8; k++) send_word(k[0], rand_sample(20000));
    endtask

    task automatic test_random();
        for (int phase_no = 0; phase_no < 6; phase_no++)
        begin
            write_reg(REG_WINDOW_LEN, $urandom_range(1, 12));
            write_reg(REG_SMOOTH_WEIGHT, $urandom);
            write_reg(REG_VOLTAGE_SCALE, $urandom);
            write_reg(REG_CURRENT_SCALE, $urandom_range(0, 1 << 20));
            write_reg(REG_CURRENT_FLOOR, $urandom_range(0, 4000));
            for (int k = 0; k < 200; k++)
                send_word($urandom_range(0, 1),
                          ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : rand_sample($urandom_range(0, 30000)));
            // Hold the sender until every reading has been delivered.
            if (phase_no == 2)
                drain();
        end
    endtask

    // Receiver stalls on its own pattern, with quiet stretches.
    always @(posedge clk)
    begin
        if (($urandom_range(0, 63)) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata[31:0], 0);
            else
            begin
                want = pending_readings.pop_front();
                if (m_axis_tuser !== want.chan)
                    report_mismatch("channel", m_axis_tuser, want.chan);
                if (m_axis_tdata[31:0] !== want.level)
                    report_mismatch("smoothed", m_axis_tdata[31:0], want.level);
                if (m_axis_tdata[55:32] !== want.rms)
                    report_mismatch("rms", m_axis_tdata[55:32], want.rms);
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        stall_mode = 0;
        errors = 0;
        burst_left = 0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_window_edges();
        test_settings();
        test_random();
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
